[rtl/red_pkg.sv]
package red_pkg;

    localparam int LEN_W  = 16;
    localparam int PCT_W  = 7;
    localparam int PROD_W = 23;
    localparam int IDX_W  = 2;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [LEN_W-1:0] COUNT_MAX = 16'hFFFF;

    // floor(x / 100) == (x * RECIP_M) >> RECIP_SHIFT for every x below 2^23.
    localparam logic [23:0] RECIP_M     = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    // Serial divider geometry.
    localparam int DIV_RW = 16;
    localparam int DIV_BW = 14;
    localparam int DIV_QW = 14;
    localparam int DIV_SW = 4;
    localparam logic [DIV_SW-1:0] DIV_BASE_STEPS = 4'd7;
    localparam logic [DIV_SW-1:0] DIV_PROB_STEPS = 4'd14;

    localparam logic [IDX_W-1:0] CFG_MIN_THR  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_THR  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_WEIGHT   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_PROB = 2'd3;

    typedef enum logic [1:0] {
        REGION_EMPTY = 2'd0,
        REGION_BELOW = 2'd1,
        REGION_BAND  = 2'd2,
        REGION_ABOVE = 2'd3
    } region_t;

    typedef struct packed {
        logic load_in;
        logic avg_mul;
        logic avg_sum;
        logic avg_scale;
        logic classify;
        logic div_start;
        logic div_sel;
        logic take_base;
        logic den_mul;
        logic den_check;
        logic take_prob;
        logic load_out;
    } red_cmd_t;

    typedef struct packed {
        logic qlen_zero;
        logic in_band;
        logic den_nonpos;
        logic div_done;
    } red_stat_t;

    function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
        return (v > PCT_FULL) ? PCT_FULL : v;
    endfunction

endpackage

[rtl/red_div.sv]
module red_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [red_pkg::DIV_RW-1:0]  rem_init,
    input  logic [red_pkg::DIV_BW-1:0]  bits_init,
    input  logic [red_pkg::DIV_RW-1:0]  divisor,
    input  logic [red_pkg::DIV_SW-1:0]  steps,
    output logic                        done,
    output logic [red_pkg::DIV_QW-1:0]  quotient
);
    import red_pkg::*;

    logic [DIV_SW-1:0] cnt_reg, cnt_next;
    logic              done_reg;
    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_BW-1:0] bits_reg;
    logic [DIV_RW-1:0] dsr_reg;
    logic [DIV_QW-1:0] quot_reg;

    logic [DIV_RW:0]   trial;
    logic [DIV_RW:0]   diff;
    logic              fits;

    // The remainder is always below the divisor, so one subtract per step
    // brings in one quotient bit.
    assign trial = {rem_reg, bits_reg[DIV_BW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = steps;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= !start && (cnt_reg == DIV_SW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            bits_reg <= bits_init;
            dsr_reg  <= divisor;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? diff[DIV_RW-1:0] : trial[DIV_RW-1:0];
            bits_reg <= {bits_reg[DIV_BW-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[rtl/red_dp.sv]
module red_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [red_pkg::IDX_W-1:0]  cfg_index,
    input  logic [red_pkg::LEN_W-1:0]  cfg_data,
    input  logic [red_pkg::LEN_W-1:0]  queue_length,
    input  logic [red_pkg::PCT_W-1:0]  random_percent,
    input  red_pkg::red_cmd_t          cmd,
    output red_pkg::red_stat_t         stat,
    output logic                       drop_mark,
    output logic [red_pkg::LEN_W-1:0]  average_length,
    output logic [1:0]                 region,
    output logic [red_pkg::PCT_W-1:0]  mark_prob_percent
);
    import red_pkg::*;

    // Configuration and running state.
    logic [LEN_W-1:0] min_thr_reg;
    logic [LEN_W-1:0] max_thr_reg;
    logic [PCT_W-1:0] weight_reg;
    logic [PCT_W-1:0] max_prob_reg;
    logic [LEN_W-1:0] avg_reg;
    logic [LEN_W-1:0] count_reg;

    // Per-request working registers.
    logic [LEN_W-1:0]  qlen_reg;
    logic [PCT_W-1:0]  rnd_reg;
    logic [PROD_W-1:0] pa_reg;
    logic [PROD_W-1:0] pb_reg;
    logic [PROD_W-1:0] sum_reg;
    logic [PROD_W-1:0] num_reg;
    logic [LEN_W-1:0]  dsr_reg;
    logic [PCT_W-1:0]  base_reg;
    logic [PROD_W-1:0] den_prod_reg;
    region_t           region_reg;
    logic              mark_reg;
    logic [PCT_W-1:0]  prob_reg;

    logic              out_mark_reg;
    logic [LEN_W-1:0]  out_avg_reg;
    region_t           out_region_reg;
    logic [PCT_W-1:0]  out_prob_reg;

    logic [PCT_W-1:0]  w;
    logic [PCT_W-1:0]  mp;
    logic [46:0]       scaled;
    logic              band;
    logic              above;
    logic              den_nonpos;
    logic [PCT_W-1:0]  den_small;
    logic [DIV_BW-1:0] prob_num;
    logic [PCT_W-1:0]  quot_sat;
    logic              prob_mark;

    logic              div_done;
    logic [DIV_QW-1:0] div_quot;
    logic [DIV_RW-1:0] div_rem_init;
    logic [DIV_BW-1:0] div_bits_init;
    logic [DIV_RW-1:0] div_divisor;
    logic [DIV_SW-1:0] div_steps;

    assign w          = clamp_pct(weight_reg);
    assign mp         = clamp_pct(max_prob_reg);
    assign scaled     = 47'(sum_reg) * 47'(RECIP_M);
    assign band       = (min_thr_reg < avg_reg) && (avg_reg < max_thr_reg);
    assign above      = max_thr_reg <= avg_reg;
    assign den_nonpos = den_prod_reg >= PROD_W'(PCT_FULL);
    assign den_small  = PCT_FULL - den_prod_reg[PCT_W-1:0];
    assign prob_num   = DIV_BW'(base_reg) * DIV_BW'(PCT_FULL);
    assign quot_sat   = (div_quot > DIV_QW'(PCT_FULL)) ? PCT_FULL : div_quot[PCT_W-1:0];
    assign prob_mark  = rnd_reg < quot_sat;

    // The base quotient is below 128, so its division starts with the top
    // sixteen numerator bits already in the remainder.
    always_comb
    begin
        if (!cmd.div_sel)
        begin
            div_rem_init  = num_reg[PROD_W-1:PROD_W-DIV_RW];
            div_bits_init = {num_reg[PROD_W-DIV_RW-1:0], (DIV_BW-(PROD_W-DIV_RW))'(0)};
            div_divisor   = dsr_reg;
            div_steps     = DIV_BASE_STEPS;
        end
        else
        begin
            div_rem_init  = '0;
            div_bits_init = prob_num;
            div_divisor   = DIV_RW'(den_small);
            div_steps     = DIV_PROB_STEPS;
        end
    end

    red_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .rem_init  (div_rem_init),
        .bits_init (div_bits_init),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_thr_reg  <= 16'd5;
            max_thr_reg  <= 16'd15;
            weight_reg   <= 7'd2;
            max_prob_reg <= 7'd10;
            avg_reg      <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MIN_THR:  min_thr_reg  <= cfg_data;
                    CFG_MAX_THR:  max_thr_reg  <= cfg_data;
                    CFG_WEIGHT:   weight_reg   <= cfg_data[PCT_W-1:0];
                    CFG_MAX_PROB: max_prob_reg <= cfg_data[PCT_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.avg_scale)
            begin
                avg_reg <= scaled[RECIP_SHIFT +: LEN_W];
            end
            if (cmd.classify)
            begin
                if (band)
                begin
                    count_reg <= (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
                end
                else
                begin
                    count_reg <= '0;
                end
            end
            if ((cmd.den_check && den_nonpos) || (cmd.take_prob && prob_mark))
            begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            qlen_reg   <= queue_length;
            rnd_reg    <= random_percent;
            region_reg <= REGION_EMPTY;
            mark_reg   <= 1'b0;
            prob_reg   <= '0;
        end
        if (cmd.avg_mul)
        begin
            pa_reg <= PROD_W'(PCT_FULL - w) * PROD_W'(avg_reg);
            pb_reg <= PROD_W'(w) * PROD_W'(qlen_reg);
        end
        if (cmd.avg_sum)
        begin
            sum_reg <= pa_reg + pb_reg;
        end
        if (cmd.classify)
        begin
            num_reg <= PROD_W'(mp) * PROD_W'(avg_reg - min_thr_reg);
            dsr_reg <= max_thr_reg - min_thr_reg;
            if (band)
            begin
                region_reg <= REGION_BAND;
            end
            else if (above)
            begin
                region_reg <= REGION_ABOVE;
                mark_reg   <= 1'b1;
            end
            else
            begin
                region_reg <= REGION_BELOW;
            end
        end
        if (cmd.take_base)
        begin
            base_reg <= div_quot[PCT_W-1:0];
        end
        if (cmd.den_mul)
        begin
            den_prod_reg <= PROD_W'(count_reg) * PROD_W'(base_reg);
        end
        // A count times base of 100 or more leaves no positive denominator.
        if (cmd.den_check && den_nonpos)
        begin
            prob_reg <= PCT_FULL;
            mark_reg <= 1'b1;
        end
        if (cmd.take_prob)
        begin
            prob_reg <= quot_sat;
            mark_reg <= prob_mark;
        end
        if (cmd.load_out)
        begin
            out_mark_reg   <= mark_reg;
            out_avg_reg    <= avg_reg;
            out_region_reg <= region_reg;
            out_prob_reg   <= prob_reg;
        end
    end

    assign stat.qlen_zero  = (qlen_reg == '0);
    assign stat.in_band    = band;
    assign stat.den_nonpos = den_nonpos;
    assign stat.div_done   = div_done;

    assign drop_mark         = out_mark_reg;
    assign average_length    = out_avg_reg;
    assign region            = out_region_reg;
    assign mark_prob_percent = out_prob_reg;

endmodule

[rtl/red_ctrl.sv]
module red_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  red_pkg::red_stat_t stat,
    output red_pkg::red_cmd_t  cmd
);
    import red_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_AVG_MUL   = 11'b000_0000_0010,
        S_AVG_SUM   = 11'b000_0000_0100,
        S_AVG_SCALE = 11'b000_0000_1000,
        S_CLASSIFY  = 11'b000_0001_0000,
        S_BASE_GO   = 11'b000_0010_0000,
        S_BASE_WAIT = 11'b000_0100_0000,
        S_DEN_MUL   = 11'b000_1000_0000,
        S_DEN_CHECK = 11'b001_0000_0000,
        S_PROB_WAIT = 11'b010_0000_0000,
        S_OUT       = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_AVG_MUL;
                end
            end
            S_AVG_MUL:
            begin
                if (stat.qlen_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.avg_mul = 1'b1;
                    state_next  = S_AVG_SUM;
                end
            end
            S_AVG_SUM:
            begin
                cmd.avg_sum = 1'b1;
                state_next  = S_AVG_SCALE;
            end
            S_AVG_SCALE:
            begin
                cmd.avg_scale = 1'b1;
                state_next    = S_CLASSIFY;
            end
            S_CLASSIFY:
            begin
                cmd.classify = 1'b1;
                state_next   = stat.in_band ? S_BASE_GO : S_OUT;
            end
            S_BASE_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_BASE_WAIT;
            end
            S_BASE_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.take_base = 1'b1;
                    state_next    = S_DEN_MUL;
                end
            end
            S_DEN_MUL:
            begin
                cmd.den_mul = 1'b1;
                state_next  = S_DEN_CHECK;
            end
            S_DEN_CHECK:
            begin
                cmd.den_check = 1'b1;
                if (stat.den_nonpos)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b1;
                    state_next    = S_PROB_WAIT;
                end
            end
            S_PROB_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.take_prob = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/red_drop_marker.sv]
// Random early detection marker for one queue.
// Input channel (in_valid/in_ready): one request per arriving packet with
// the current queue_length and a random_percent value from 0 to 99.
// Output channel (out_valid/out_ready): one result per request with the
// mark decision, the updated average length, the region and the marking
// probability. Configuration channel (cfg_valid/cfg_ready) is always ready;
// index 0 min threshold, 1 max threshold, 2 weight, 3 max probability.
// An empty queue goes straight to the result; outside the threshold band
// the average is updated and classified first; inside it a shared
// one-bit-per-cycle divider then runs 7 steps for the base probability
// and, unless the count times the base probability leaves no positive
// denominator, 14 steps for the adjusted probability. One request is in
// flight at a time, so a new one waits until the last result is registered.
// The result sits in an output register; a new request is taken while it
// waits, and a finished result is held until the receiver takes the one
// ahead of it. Reset restores the default configuration and clears the
// average and the count of packets since the last mark.
module red_drop_marker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] queue_length,
    input  logic [6:0]  random_percent,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drop_mark,
    output logic [15:0] average_length,
    output logic [1:0]  region,
    output logic [6:0]  mark_prob_percent
);
    import red_pkg::*;

    red_cmd_t  cmd;
    red_stat_t stat;

    assign cfg_ready = 1'b1;

    red_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    red_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .queue_length      (queue_length),
        .random_percent    (random_percent),
        .cmd               (cmd),
        .stat              (stat),
        .drop_mark         (drop_mark),
        .average_length    (average_length),
        .region            (region),
        .mark_prob_percent (mark_prob_percent)
    );

    // Only one request is worked on at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request accepted while one is in progress");

    // A finished result never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("pending result overwritten");

    // An empty queue neither marks nor reports a probability.
    a_empty_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (region == REGION_EMPTY)) |-> (!drop_mark && (mark_prob_percent == '0)))
        else $error("empty queue result carries a mark");

    // Below the band nothing is marked; above it everything is.
    a_region_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((region == REGION_BELOW) && drop_mark)
                      && !((region == REGION_ABOVE) && !drop_mark))
        else $error("mark decision disagrees with region");

endmodule
